FILE: hdl/distance_persistence_qualifier_unit_macros.svh
// Assertion macros for the distance persistence qualifier.
`ifndef DISTANCE_PERSISTENCE_QUALIFIER_UNIT_MACROS_SVH
`define DISTANCE_PERSISTENCE_QUALIFIER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define DPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define DPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/dpq_pkg.sv
// Shared types and constants for the distance persistence qualifier.
package dpq_pkg;

  localparam int CH_W       = 2;
  localparam int ADC_W      = 12;
  localparam int DIST_W     = 12;
  localparam int SLOPE_W    = 16;
  localparam int OFFSET_W   = 22;
  localparam int THR_W      = 12;
  localparam int REQ_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 22;
  localparam int PROD_W     = SLOPE_W + ADC_W;
  localparam int SUM_W      = PROD_W + 2;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam int DEF_NUM_CHANNELS = 4;
  localparam int DEF_COUNT_BITS   = 4;

  localparam logic [SLOPE_W-1:0]         SLOPE_RESET  = 16'd5089;
  localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = -22'sd636140;
  localparam logic [THR_W-1:0]           THR_RESET    = 12'd60;
  localparam logic [REQ_W-1:0]           REQ_RESET    = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOPE     = 2'd0,
    CFG_OFFSET    = 2'd1,
    CFG_THRESHOLD = 2'd2,
    CFG_REQUIRED  = 2'd3
  } cfg_index_t;

  // Converted distance travelling from the conversion stage to the qualifier.
  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [DIST_W-1:0] distance;
  } dist_req_t;

endpackage

FILE: hdl/dpq_if.sv
// Request and result channels of the distance persistence qualifier.
interface dpq_in_if
  import dpq_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   channel;
  logic [ADC_W-1:0]  adc_sample;

  modport source (output valid, output channel, output adc_sample, input ready);
  modport sink   (input valid, input channel, input adc_sample, output ready);
endinterface

interface dpq_out_if
  import dpq_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_cm;
  logic [DIST_W-1:0] qualified_cm;
  logic [CH_W-1:0]   out_channel;

  modport source (output valid, output distance_cm, output qualified_cm,
                  output out_channel, input ready);
  modport sink   (input valid, input distance_cm, input qualified_cm,
                  input out_channel, output ready);
endinterface

FILE: hdl/distance_persistence_qualifier_unit.sv
// Top level of the distance persistence qualifier: config registers and stages.
//
// Converts 12-bit ultrasonic ADC samples to centimeters (slope * adc + offset
// in Q16, negative sums give 0, large ones saturate at 4095) and applies a
// per-channel persistence rule: a reading at or below the threshold is only
// passed once required_count consecutive such readings have been seen on that
// channel; until then the channel's last reading above the threshold is
// repeated, and a first reading at or below the threshold reports
// threshold + 1. One request is taken per clock unless the result side is
// stalled, and every request gives exactly one result. The datapath is:
// input register, then multiply-add, clamp and per-channel state update as
// one combinational pass into the result register. Per-channel state is read
// and written in that pass only, so back-to-back requests on the same
// channel need no forwarding. The input register moves when it is empty or
// when the result register is empty or being drained, so a stalled result
// still leaves room for one request behind it. Config registers are written
// through cfg_wr_en/cfg_index/cfg_data and should only change while no
// request is in flight. Channels at or above NUM_CHANNELS keep no state and
// report the raw distance as qualified.
`include "distance_persistence_qualifier_unit_macros.svh"

module distance_persistence_qualifier_unit
  import dpq_pkg::*;
#(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  dpq_in_if.sink                samples,
  dpq_out_if.source             results
);

  // Configuration registers
  logic [SLOPE_W-1:0]         slope_q16;
  logic signed [OFFSET_W-1:0] offset_q16;
  logic [THR_W-1:0]           threshold_cm;
  logic [REQ_W-1:0]           required_count;

  // Conversion -> qualifier stream
  logic      conv_valid;
  logic      conv_ready;
  dist_req_t conv_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      slope_q16      <= SLOPE_RESET;
      offset_q16     <= OFFSET_RESET;
      threshold_cm   <= THR_RESET;
      required_count <= REQ_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SLOPE:     slope_q16      <= cfg_data[SLOPE_W-1:0];
        CFG_OFFSET:    offset_q16     <= $signed(cfg_data[OFFSET_W-1:0]);
        CFG_THRESHOLD: threshold_cm   <= cfg_data[THR_W-1:0];
        CFG_REQUIRED:  required_count <= cfg_data[REQ_W-1:0];
        default:       ;
      endcase
    end
  end

  dpq_convert u_convert (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .slope      (slope_q16),
    .offset     (offset_q16),
    .dist_valid (conv_valid),
    .dist_ready (conv_ready),
    .dist_req   (conv_req)
  );

  dpq_qualify #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_qualify (
    .clk        (clk),
    .rst        (rst),
    .dist_valid (conv_valid),
    .dist_ready (conv_ready),
    .dist_req   (conv_req),
    .threshold  (threshold_cm),
    .required   (required_count),
    .results    (results)
  );

  // An empty result register lets the whole pipeline advance.
  `DPQ_ASSERT_NOW(a_ready_when_drained, !results.valid, samples.ready && conv_ready, "pipeline stalled with empty result register")
  // A stalled distance request keeps its payload.
  `DPQ_ASSERT_NEXT(a_conv_hold, conv_valid && !conv_ready, conv_valid && $stable(conv_req), "distance request changed while stalled")
  // A distance request taken by the qualifier shows up as a result.
  `DPQ_ASSERT_NEXT(a_conv_to_result, conv_valid && conv_ready, results.valid && results.distance_cm == $past(conv_req.distance), "qualifier dropped a request")

endmodule

FILE: hdl/dpq_convert.sv
// Input register and ADC-to-centimeter conversion stage.
module dpq_convert
  import dpq_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  dpq_in_if.sink                       samples,
  input  logic [SLOPE_W-1:0]           slope,
  input  logic signed [OFFSET_W-1:0]   offset,
  output logic                         dist_valid,
  input  logic                         dist_ready,
  output dist_req_t                    dist_req
);

  logic              in_valid;
  logic [CH_W-1:0]   in_channel;
  logic [ADC_W-1:0]  in_adc;
  logic              adv_in;
  logic [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0] sum;

  assign adv_in        = !in_valid || dist_ready;
  assign samples.ready = adv_in;
  assign dist_valid    = in_valid;

  // slope * adc + offset, Q16; negative -> 0, saturate at DIST_MAX
  always_comb begin
    prod = PROD_W'(slope) * PROD_W'(in_adc);
    sum  = $signed({2'b00, prod}) + SUM_W'(offset);
    dist_req.channel = in_channel;
    if (sum[SUM_W-1]) begin
      dist_req.distance = '0;
    end else if (|sum[SUM_W-2:16+DIST_W]) begin
      dist_req.distance = DIST_MAX;
    end else begin
      dist_req.distance = sum[16+DIST_W-1:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (adv_in) begin
      in_valid <= samples.valid;
    end
    if (adv_in && samples.valid) begin
      in_channel <= samples.channel;
      in_adc     <= samples.adc_sample;
    end
  end

endmodule

FILE: hdl/dpq_qualify.sv
// Per-channel persistence state and result register.
module dpq_qualify
  import dpq_pkg::*;
#(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              dist_valid,
  output logic              dist_ready,
  input  dist_req_t         dist_req,
  input  logic [THR_W-1:0]  threshold,
  input  logic [REQ_W-1:0]  required,
  dpq_out_if.source         results
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CMP_W = (COUNT_BITS > REQ_W) ? COUNT_BITS : REQ_W;
  localparam logic [4:0]            NUM_CH5   = 5'(NUM_CHANNELS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [NUM_CHANNELS-1:0] first_reading;
  logic [COUNT_BITS-1:0]   below_count [NUM_CHANNELS];
  logic [DIST_W-1:0]       last_above  [NUM_CHANNELS];

  logic                  take;
  logic                  hit;
  logic [IDX_W-1:0]      idx;
  logic [COUNT_BITS-1:0] cnt_cur;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [COUNT_BITS-1:0] cnt_next;
  logic [DIST_W-1:0]     last_cur;
  logic [DIST_W-1:0]     last_next;
  logic [DIST_W-1:0]     thr_up;
  logic [DIST_W-1:0]     qual;
  logic                  at_or_below;

  assign dist_ready = !results.valid || results.ready;
  assign take       = dist_valid && dist_ready;

  always_comb begin
    hit         = ({3'b000, dist_req.channel} < NUM_CH5);
    idx         = IDX_W'(dist_req.channel);
    cnt_cur     = below_count[idx];
    last_cur    = last_above[idx];
    cnt_inc     = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
    thr_up      = (threshold == DIST_MAX) ? threshold : threshold + 1'b1;
    at_or_below = (dist_req.distance <= threshold);
    cnt_next    = cnt_cur;
    last_next   = last_cur;
    qual        = dist_req.distance;
    if (first_reading[idx]) begin
      if (at_or_below) begin
        last_next = thr_up;
        qual      = thr_up;
        cnt_next  = cnt_inc;
      end else begin
        last_next = dist_req.distance;
      end
    end else if (at_or_below) begin
      cnt_next = cnt_inc;
      qual     = (CMP_W'(cnt_inc) >= CMP_W'(required)) ? dist_req.distance : last_cur;
    end else begin
      last_next = dist_req.distance;
      cnt_next  = '0;
    end
    if (!hit) begin
      qual = dist_req.distance;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_reading <= '1;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        below_count[i] <= '0;
        last_above[i]  <= '0;
      end
    end else if (take && hit) begin
      first_reading[idx] <= 1'b0;
      below_count[idx]   <= cnt_next;
      last_above[idx]    <= last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (take) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
    if (take) begin
      results.distance_cm  <= dist_req.distance;
      results.qualified_cm <= qual;
      results.out_channel  <= dist_req.channel;
    end
  end

endmodule
